/* src/golden_nonce_dedup_filter_assert.svh */
// ----------------------------------------------------------------------------
// golden_nonce_dedup_filter_assert.svh
// assertion macros for the duplicate filter, empty bodies under SYNTH
// ----------------------------------------------------------------------------
`ifndef GOLDEN_NONCE_DEDUP_FILTER_ASSERT_SVH
`define GOLDEN_NONCE_DEDUP_FILTER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define GNDF_ASSERT_NOW(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("gndf assertion failed");
// next-cycle implication
`define GNDF_ASSERT_NEXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("gndf assertion failed");
`else
`define GNDF_ASSERT_NOW(name, ck, rn, ante, cons)
`define GNDF_ASSERT_NEXT(name, ck, rn, ante, cons)
`endif
`endif

/* src/gndf_pkg.sv */
// ----------------------------------------------------------------------------
// gndf_pkg
// shared types and constants of the duplicate filter
// ----------------------------------------------------------------------------
package gndf_pkg;

	localparam int DEF_MAX_ENGINES   = 8;
	localparam int DEF_MAX_EXTRA     = 3;
	localparam int DEF_BACKLOG_DEPTH = 40;

	localparam int NUM_SLOTS   = 4;
	localparam int ENG_W       = 5;   // holds an engine count up to 31
	localparam int QUEUE_DEPTH = 2;

	localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

	typedef enum logic [1:0] {
		REG_ENGINES = 2'd0,
		REG_EXTRA   = 2'd1,
		REG_EMPTY   = 2'd2
	} reg_idx_t;

	typedef enum logic {
		ACT_REPORT   = 1'b0,
		ACT_NEW_WORK = 1'b1
	} action_t;

	typedef struct packed {
		logic        action;
		logic [2:0]  engine;
		logic [31:0] progress;
		logic [31:0] found_0;
		logic [31:0] found_1;
		logic [31:0] found_2;
		logic [31:0] found_3;
	} req_t;

	typedef struct packed {
		logic [1:0]  slot;
		logic [31:0] value;
		logic        submit;
		logic        verify_needed;
		logic        overflow;
		logic [31:0] highest_progress;
		logic        last;
	} res_t;

	// effective configuration after saturation
	typedef struct packed {
		logic [ENG_W-1:0] eng_eff;
		logic [1:0]       extra_eff;
		logic [31:0]      empty_marker;
	} cfg_t;

	// one queued job: a backlog clear or a classified report
	typedef struct packed {
		logic                        is_clear;
		logic [NUM_SLOTS-1:0][31:0]  found;
		logic [1:0]                  extra;
		logic                        overflow;
		logic [31:0]                 highest;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* src/gndf_ifs.sv */
// ----------------------------------------------------------------------------
// gndf_ifs
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface gndf_req_if;
	logic           valid;
	logic           ready;
	gndf_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gndf_res_if;
	logic           valid;
	logic           ready;
	gndf_pkg::res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/gndf_front.sv */
// ----------------------------------------------------------------------------
// gndf_front
// accepts requests, runs the progress check and queues jobs for the back end
// ----------------------------------------------------------------------------
module gndf_front #(
	parameter int MAX_ENGINES = gndf_pkg::DEF_MAX_ENGINES
) (
	input  logic            clk,
	input  logic            arst_n,
	gndf_req_if.sink        req,
	input  gndf_pkg::cfg_t  cfg,
	input  gndf_pkg::q_stat_t q_stat,
	output logic            push,
	output gndf_pkg::job_t  job
);

	localparam int EW = (MAX_ENGINES > 1) ? $clog2(MAX_ENGINES) : 1;

	logic [31:0] last_prog_q [MAX_ENGINES];
	logic        ovf_q;
	logic [31:0] max_q;

	logic          accept;
	logic          in_range;
	logic [EW-1:0] eng_idx;
	logic [31:0]   prev;
	logic          bad;
	logic          new_max;

	assign req.ready = !q_stat.full;
	assign accept    = req.valid && req.ready;

	assign in_range = ({2'b00, req.data.engine} < cfg.eng_eff)
		&& (32'(req.data.engine) < 32'(MAX_ENGINES));
	assign eng_idx  = EW'(req.data.engine);
	assign prev     = last_prog_q[eng_idx];
	// wrap or step backward
	assign bad      = ((gndf_pkg::ALL_ONES - req.data.progress) < (req.data.progress - prev))
		|| (req.data.progress < prev);
	assign new_max  = req.data.progress > max_q;

	assign push = accept
		&& ((req.data.action == gndf_pkg::ACT_NEW_WORK) || in_range);

	always_comb begin
		job.is_clear = (req.data.action == gndf_pkg::ACT_NEW_WORK);
		job.found[0] = req.data.found_0;
		job.found[1] = req.data.found_1;
		job.found[2] = req.data.found_2;
		job.found[3] = req.data.found_3;
		job.extra    = cfg.extra_eff;
		job.overflow = ovf_q || bad;
		job.highest  = new_max ? req.data.progress : max_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
			max_q <= '0;
			for (int i = 0; i < MAX_ENGINES; i++) last_prog_q[i] <= '0;
		end else if (accept) begin
			if (req.data.action == gndf_pkg::ACT_NEW_WORK) begin
				ovf_q <= 1'b0;
				max_q <= '0;
				for (int i = 0; i < MAX_ENGINES; i++) last_prog_q[i] <= '0;
			end else if (in_range) begin
				if (new_max) max_q <= req.data.progress;
				if (bad) begin
					ovf_q <= 1'b1;
				end else begin
					last_prog_q[eng_idx] <= req.data.progress;
				end
			end
		end
	end

endmodule

/* src/gndf_queue.sv */
// ----------------------------------------------------------------------------
// gndf_queue
// short job queue between front and back end
// ----------------------------------------------------------------------------
module gndf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gndf_pkg::job_t    job_in,
	input  logic              pop,
	output gndf_pkg::job_t    head,
	output gndf_pkg::q_stat_t stat
);

	localparam int PW = (gndf_pkg::QUEUE_DEPTH > 1) ? $clog2(gndf_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(gndf_pkg::QUEUE_DEPTH + 1);

	gndf_pkg::job_t entry_q [gndf_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign stat.full  = (count_q == CW'(gndf_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == gndf_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == gndf_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/gndf_back.sv */
// ----------------------------------------------------------------------------
// gndf_back
// backlog search, insert and result output, one slot at a time
// ----------------------------------------------------------------------------
module gndf_back #(
	parameter int BACKLOG_DEPTH = gndf_pkg::DEF_BACKLOG_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gndf_pkg::cfg_t    cfg,
	input  gndf_pkg::job_t    head,
	input  gndf_pkg::q_stat_t q_stat,
	output logic              pop,
	gndf_res_if.source        res
);

	localparam int AW   = $clog2(BACKLOG_DEPTH);
	localparam int LENW = AW + 1;
	localparam int PRW  = gndf_pkg::ENG_W + 3;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LOAD   = 4'b0010,
		ST_SEARCH = 4'b0100,
		ST_OUT    = 4'b1000
	} state_t;

	state_t state_q;

	logic [31:0]              mem_q [BACKLOG_DEPTH];
	logic [BACKLOG_DEPTH-1:0] vld_q;
	logic [AW-1:0]            wp_q;
	logic [1:0]               slot_q;
	logic [31:0]              val_q;
	logic [AW-1:0]            search_idx_q;
	logic                     issue_done_q;
	logic                     cmp_vld_s1;
	logic                     cmp_last_s1;
	logic [31:0]              rd_mem_s1;
	logic                     rd_vld_s1;
	gndf_pkg::res_t           res_q;

	logic [PRW-1:0]  prod;
	logic [LENW-1:0] blen;
	logic            issuing;
	logic            issue_last;
	logic            hit;
	logic            insert;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   wnext;
	logic [31:0]     slot_val;
	logic            is_last_slot;

	// backlog length, saturated to the memory depth
	assign prod = PRW'(cfg.eng_eff) * PRW'(3'd2 + 3'(cfg.extra_eff));
	assign blen = (32'(prod) > 32'(BACKLOG_DEPTH)) ? LENW'(BACKLOG_DEPTH) : LENW'(prod);

	assign issuing    = (state_q == ST_SEARCH) && !issue_done_q;
	assign issue_last = (LENW'(search_idx_q) == blen - 1'b1);
	// entries never written since clear read as zero
	assign hit        = cmp_vld_s1 && ((rd_vld_s1 ? rd_mem_s1 : 32'd0) == val_q);
	assign insert     = (state_q == ST_SEARCH) && cmp_vld_s1 && cmp_last_s1 && !hit;

	assign waddr = (LENW'(wp_q) >= blen) ? '0 : wp_q;
	assign wnext = ((LENW'(waddr) + 1'b1) >= blen) ? '0 : AW'(waddr + 1'b1);

	assign slot_val     = head.found[slot_q];
	assign is_last_slot = (slot_q == head.extra);

	assign res.valid = (state_q == ST_OUT);
	assign res.data  = res_q;

	assign pop = ((state_q == ST_IDLE) && !q_stat.empty && head.is_clear)
		|| ((state_q == ST_OUT) && res.ready && res_q.last);

	// backlog memory
	always_ff @(posedge clk) begin
		if (insert) mem_q[waddr] <= val_q;
		rd_mem_s1 <= mem_q[search_idx_q];
		rd_vld_s1 <= vld_q[search_idx_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) val_q <= slot_val;
		if ((state_q == ST_LOAD) || (state_q == ST_SEARCH)) begin
			res_q.slot             <= slot_q;
			res_q.overflow         <= head.overflow;
			res_q.highest_progress <= head.highest;
			res_q.last             <= is_last_slot;
		end
		if (state_q == ST_LOAD) begin
			res_q.value         <= slot_val;
			res_q.submit        <= 1'b0;
			res_q.verify_needed <= 1'b0;
		end else if (state_q == ST_SEARCH) begin
			res_q.value         <= val_q;
			res_q.submit        <= insert;
			res_q.verify_needed <= insert && (slot_q != 2'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vld_q        <= '0;
			wp_q         <= '0;
			slot_q       <= '0;
			search_idx_q <= '0;
			issue_done_q <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			cmp_last_s1  <= 1'b0;
		end else begin
			cmp_vld_s1  <= issuing;
			cmp_last_s1 <= issue_last;
			if (issuing) begin
				search_idx_q <= search_idx_q + 1'b1;
				if (issue_last) issue_done_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						if (head.is_clear) begin
							vld_q <= '0;
							wp_q  <= '0;
						end else begin
							slot_q  <= '0;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					search_idx_q <= '0;
					issue_done_q <= 1'b0;
					if (slot_val == cfg.empty_marker) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						state_q <= ST_OUT;
					end else if (insert) begin
						vld_q[waddr] <= 1'b1;
						wp_q         <= wnext;
						state_q      <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (res.ready) begin
						if (res_q.last) begin
							state_q <= ST_IDLE;
						end else begin
							slot_q  <= slot_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* src/golden_nonce_dedup_filter.sv */
// flow: a report is classified in its accept cycle and queued; the back end picks it up once
// idle and loads each used slot, which goes straight to its result when empty, else searches
// the backlog (one backlog read per cycle, len = engines*(2+extra) saturated) and inserts the
// value on a miss; results wait for res.ready. The back end takes one report at a time, bound
// by the single read port of the backlog memory; a new-work request just clears the backlog
// reset: arst_n clears state, backlog valid bits and registers at once, no sweep
// ----------------------------------------------------------------------------
// golden_nonce_dedup_filter
// duplicate filter for found values reported by hashing engines
// ----------------------------------------------------------------------------
`include "golden_nonce_dedup_filter_assert.svh"

module golden_nonce_dedup_filter #(
	parameter int MAX_ENGINES   = gndf_pkg::DEF_MAX_ENGINES,
	parameter int MAX_EXTRA     = gndf_pkg::DEF_MAX_EXTRA,
	parameter int BACKLOG_DEPTH = gndf_pkg::DEF_BACKLOG_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request and result channels
	gndf_req_if.sink    req,
	gndf_res_if.source  res
);

	// configuration registers
	logic [3:0]  eng_q;
	logic [1:0]  extra_q;
	logic [31:0] empty_q;

	logic                 cfg_wr;
	gndf_pkg::reg_idx_t   reg_idx;
	gndf_pkg::cfg_t       cfg;

	// front to queue to back
	logic                 q_push;
	logic                 q_pop;
	gndf_pkg::job_t       q_in;
	gndf_pkg::job_t       q_head;
	gndf_pkg::q_stat_t    q_stat;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = gndf_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q   <= 4'd1;
			extra_q <= 2'd0;
			empty_q <= 32'd0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				gndf_pkg::REG_ENGINES: eng_q   <= pwdata[3:0];
				gndf_pkg::REG_EXTRA:   extra_q <= pwdata[1:0];
				gndf_pkg::REG_EMPTY:   empty_q <= pwdata;
				default: ;   // unmapped address, write dropped
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_idx)
			gndf_pkg::REG_ENGINES: prdata = {28'd0, eng_q};
			gndf_pkg::REG_EXTRA:   prdata = {30'd0, extra_q};
			gndf_pkg::REG_EMPTY:   prdata = empty_q;
			default:               prdata = 32'd0;
		endcase
	end

	// saturate engine count to 1..MAX_ENGINES and extra slots to MAX_EXTRA
	always_comb begin
		if (eng_q == 4'd0) begin
			cfg.eng_eff = gndf_pkg::ENG_W'(1);
		end else if (32'(eng_q) > 32'(MAX_ENGINES)) begin
			cfg.eng_eff = gndf_pkg::ENG_W'(MAX_ENGINES);
		end else begin
			cfg.eng_eff = gndf_pkg::ENG_W'(eng_q);
		end
		cfg.extra_eff    = (32'(extra_q) > 32'(MAX_EXTRA)) ? 2'(MAX_EXTRA) : extra_q;
		cfg.empty_marker = empty_q;
	end

	// front end: progress check, highest progress, engine range check
	gndf_front #(
		.MAX_ENGINES (MAX_ENGINES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg),
		.q_stat (q_stat),
		.push   (q_push),
		.job    (q_in)
	);

	// job queue; the front keeps accepting while the back end works, until the queue is full
	gndf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.job_in (q_in),
		.pop    (q_pop),
		.head   (q_head),
		.stat   (q_stat)
	);

	// back end: backlog search and insert, one result per used slot
	gndf_back #(
		.BACKLOG_DEPTH (BACKLOG_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.head   (q_head),
		.q_stat (q_stat),
		.pop    (q_pop),
		.res    (res)
	);

	// front never pushes into a full queue, back never pops an empty one
	`GNDF_ASSERT_NOW(a_push_not_full, clk, arst_n, q_push, !q_stat.full)
	`GNDF_ASSERT_NOW(a_pop_not_empty, clk, arst_n, q_pop, !q_stat.empty)
	// verification only for a submitted value from a later slot
	`GNDF_ASSERT_NOW(a_verify_rule, clk, arst_n, res.valid && res.data.verify_needed,
		res.data.submit && (res.data.slot != 2'd0))
	// the last result of a report releases its queue entry
	`GNDF_ASSERT_NEXT(a_last_pops, clk, arst_n, res.valid && res.ready && res.data.last,
		!res.valid)

endmodule
